// File: design/fba_pkg.sv
// Shared types and constants of the fit block allocator.
`default_nettype none

package fba_pkg;

  // Input word kinds
  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_ALLOC  = 1'b1;

  // Fit strategy register values
  localparam logic STRAT_FIRST_FIT = 1'b0;
  localparam logic STRAT_BEST_FIT  = 1'b1;

  // Port widths of the result word
  localparam int unsigned SIZE_PORT_W  = 16;
  localparam int unsigned INDEX_PORT_W = 5;
  localparam int unsigned COUNT_PORT_W = 6;

  typedef enum logic [1:0] {
    FBA_ST_OK      = 2'd0,
    FBA_ST_NOFIT   = 2'd1,
    FBA_ST_FULL    = 2'd2,
    FBA_ST_NOSPLIT = 2'd3
  } fba_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_SCAN,
    S_GRANT,
    S_SHIFT,
    S_INSERT,
    S_DONE
  } fba_state_e;

  typedef struct packed {
    logic        load;
    logic        append_wr;
    logic        scan;
    logic        grant;
    logic        shift;
    logic        insert;
    logic        set_st;
    fba_status_e st;
    logic        emit;
  } fba_cmd_t;

  typedef struct packed {
    logic full;
    logic scan_done;
    logic found;
    logic rem_zero;
    logic shift_done;
    logic out_free;
  } fba_stat_t;

endpackage

`default_nettype wire

// File: design/fba_ctrl.sv
// Sequencing state machine of the fit block allocator.
`default_nettype none

module fba_ctrl
  import fba_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      kind_i,
  output logic           in_ready_o,
  input  wire fba_stat_t stat_i,
  output fba_cmd_t       cmd_o
);

  fba_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.st   = FBA_ST_OK;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (kind_i == KIND_ALLOC) ? S_SCAN : S_APPEND;
        end
      end
      S_APPEND: begin
        cmd_o.set_st = 1'b1;
        if (stat_i.full) begin
          cmd_o.st = FBA_ST_FULL;
        end else begin
          cmd_o.append_wr = 1'b1;
          cmd_o.st        = FBA_ST_OK;
        end
        state_d = S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          if (stat_i.found) begin
            state_d = S_GRANT;
          end else begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = FBA_ST_NOFIT;
            state_d      = S_DONE;
          end
        end
      end
      S_GRANT: begin
        cmd_o.grant = 1'b1;
        if (stat_i.rem_zero) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = FBA_ST_OK;
          state_d      = S_DONE;
        end else if (stat_i.full) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = FBA_ST_NOSPLIT;
          state_d      = S_DONE;
        end else begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (stat_i.shift_done) begin
          state_d = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd_o.insert = 1'b1;
        cmd_o.set_st = 1'b1;
        cmd_o.st     = FBA_ST_OK;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/fba_dp.sv
// Datapath of the fit block allocator: block table, scan, shift and result register.
`default_nettype none

module fba_dp
  import fba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 32,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire fba_cmd_t                cmd_i,
  output fba_stat_t                    stat_o,
  input  wire logic                    kind_i,
  input  wire logic [SIZE_PORT_W-1:0]  size_units_i,
  input  wire logic                    starts_free_i,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic                    fit_strategy_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [1:0]                   status_o,
  output logic [INDEX_PORT_W-1:0]      block_index_o,
  output logic [SIZE_PORT_W-1:0]       original_size_o,
  output logic [SIZE_PORT_W-1:0]       remainder_size_o,
  output logic [COUNT_PORT_W-1:0]      block_count_o
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_BLOCKS);

  // Entry layout: free mark on top, size below
  logic [SIZE_BITS:0] mem [MAX_BLOCKS];
  logic [SIZE_BITS:0] rdata_q;

  logic                 kind_q;
  logic                 sfree_q;
  logic [SIZE_BITS-1:0] req_q;
  logic                 strat_q;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        rd_idx_q;
  logic                 cmp_vld_q;
  logic [IW-1:0]        cmp_idx_q;
  logic                 found_q;
  logic [IW-1:0]        pick_q;
  logic [SIZE_BITS-1:0] best_q;
  logic [CW-1:0]        sh_ptr_q;
  logic                 sh_vld_q;
  logic [IW-1:0]        sh_wa_q;
  logic [IW-1:0]        res_idx_q;
  logic [SIZE_BITS-1:0] res_orig_q;
  logic [SIZE_BITS-1:0] res_rem_q;
  fba_status_e          res_st_q;

  logic                    out_valid_q, out_valid_d;
  fba_status_e             out_st_q;
  logic [INDEX_PORT_W-1:0] out_idx_q;
  logic [SIZE_PORT_W-1:0]  out_orig_q;
  logic [SIZE_PORT_W-1:0]  out_rem_q;
  logic [COUNT_PORT_W-1:0] out_cnt_q;

  logic                 full;
  logic                 hit;
  logic                 take;
  logic                 ff_stop;
  logic                 scan_rd;
  logic                 sh_rd;
  logic [CW-1:0]        sh_prev;
  logic [CW-1:0]        pick_p1;
  logic [SIZE_BITS-1:0] rem;
  logic [31:0]          size_ext;
  logic [31:0]          idx_ext;
  logic [31:0]          orig_ext;
  logic [31:0]          rem_ext;
  logic [31:0]          cnt_ext;
  logic                 re;
  logic [IW-1:0]        raddr;
  logic                 we;
  logic [IW-1:0]        waddr;
  logic [SIZE_BITS:0]   wdata;

  assign full     = (count_q == MaxCount);
  assign hit      = cmp_vld_q && rdata_q[SIZE_BITS] && (rdata_q[SIZE_BITS-1:0] >= req_q);
  assign take     = hit && (!found_q ||
                    ((strat_q == STRAT_BEST_FIT) && (rdata_q[SIZE_BITS-1:0] < best_q)));
  assign ff_stop  = (strat_q == STRAT_FIRST_FIT) && found_q;
  assign scan_rd  = cmd_i.scan && (rd_idx_q < count_q) && !ff_stop;
  assign pick_p1  = CW'(pick_q) + CW'(1);
  assign sh_rd    = cmd_i.shift && (sh_ptr_q > pick_p1);
  assign sh_prev  = sh_ptr_q - CW'(1);
  assign rem      = best_q - req_q;
  assign size_ext = 32'(size_units_i);
  assign idx_ext  = 32'(res_idx_q);
  assign orig_ext = 32'(res_orig_q);
  assign rem_ext  = 32'(res_rem_q);
  assign cnt_ext  = 32'(count_q);

  assign stat_o.full       = full;
  assign stat_o.scan_done  = !cmp_vld_q && ((rd_idx_q >= count_q) || ff_stop);
  assign stat_o.found      = found_q;
  assign stat_o.rem_zero   = (rem == '0);
  assign stat_o.shift_done = !sh_rd && !sh_vld_q;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign re    = scan_rd || sh_rd;
  assign raddr = scan_rd ? rd_idx_q[IW-1:0] : sh_prev[IW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd_i.append_wr) begin
      we    = 1'b1;
      waddr = count_q[IW-1:0];
      wdata = {sfree_q, req_q};
    end else if (cmd_i.grant) begin
      we    = 1'b1;
      waddr = pick_q;
      wdata = {1'b0, req_q};
    end else if (cmd_i.shift && sh_vld_q) begin
      we    = 1'b1;
      waddr = sh_wa_q;
      wdata = rdata_q;
    end else if (cmd_i.insert) begin
      we    = 1'b1;
      waddr = pick_p1[IW-1:0];
      wdata = {1'b1, rem};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.append_wr || cmd_i.insert) begin
      count_d = count_q + CW'(1);
    end
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      strat_q     <= STRAT_FIRST_FIT;
      out_valid_q <= 1'b0;
      cmp_vld_q   <= 1'b0;
      sh_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      rd_idx_q    <= '0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      cmp_vld_q   <= scan_rd;
      sh_vld_q    <= sh_rd;
      if (cfg_valid_i) begin
        strat_q <= fit_strategy_i;
      end
      if (cmd_i.load) begin
        found_q  <= 1'b0;
        rd_idx_q <= '0;
      end else begin
        if (take) begin
          found_q <= 1'b1;
        end
        if (scan_rd) begin
          rd_idx_q <= rd_idx_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q     <= kind_i;
      req_q      <= size_ext[SIZE_BITS-1:0];
      sfree_q    <= starts_free_i;
      res_idx_q  <= '0;
      res_orig_q <= '0;
      res_rem_q  <= '0;
    end
    if (scan_rd) begin
      cmp_idx_q <= rd_idx_q[IW-1:0];
    end
    if (take) begin
      pick_q <= cmp_idx_q;
      best_q <= rdata_q[SIZE_BITS-1:0];
    end
    if (cmd_i.append_wr) begin
      res_idx_q  <= count_q[IW-1:0];
      res_orig_q <= req_q;
    end
    if (cmd_i.grant) begin
      res_idx_q  <= pick_q;
      res_orig_q <= best_q;
      sh_ptr_q   <= count_q;
    end
    if (sh_rd) begin
      sh_wa_q  <= sh_ptr_q[IW-1:0];
      sh_ptr_q <= sh_prev;
    end
    if (cmd_i.insert) begin
      res_rem_q <= rem;
    end
    if (cmd_i.set_st) begin
      res_st_q <= cmd_i.st;
    end
    if (cmd_i.emit) begin
      out_st_q   <= res_st_q;
      out_idx_q  <= idx_ext[INDEX_PORT_W-1:0];
      out_orig_q <= orig_ext[SIZE_PORT_W-1:0];
      out_rem_q  <= rem_ext[SIZE_PORT_W-1:0];
      out_cnt_q  <= cnt_ext[COUNT_PORT_W-1:0];
    end
  end

  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_st_q;
  assign block_index_o    = out_idx_q;
  assign original_size_o  = out_orig_q;
  assign remainder_size_o = out_rem_q;
  assign block_count_o    = out_cnt_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCount)
    else $error("block count beyond table depth");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1)))
    else $error("block count moved by more than one");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while still held");

  a_grant_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.grant |-> (found_q && (kind_q == KIND_ALLOC)))
    else $error("grant without a fitting block");

  a_insert_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |-> (count_q < MaxCount) && (pick_p1 < count_q + CW'(1)))
    else $error("split inserted into a full table");

endmodule

`default_nettype wire

// File: design/fit_block_allocator.sv
// Top level of the fit block allocator: controller plus datapath.
`default_nettype none

// Fit block allocator. Holds an ordered table of up to MAX_BLOCKS memory
// blocks (size plus free mark) in a single-port-write, registered-read RAM
// and serves one input word at a time. An append word (kind 0) adds a block
// at the end of the table; an allocate word (kind 1) searches for a free
// block at least as large as the request, first fit or best fit as the
// fit_strategy register selects (write it only while the block is idle).
// The chosen block shrinks to the request and is marked used; a nonzero
// remainder is inserted right after it as a free block, the tail of the
// table moving up one place, or is dropped with status 3 when the table is
// full. A scan reads the whole table for best fit or a miss, and up to one
// past the hit for first fit. A split moves the tail of the table up
// through the RAM read port one entry per cycle. A finished result waits
// in an output register, and the block is ready for the next word in the
// same cycle that the result is raised, while that result is still
// unclaimed. The table is not cleared at reset; only entries below the
// block count are read.
module fit_block_allocator
  import fba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 32,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // input words
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   kind_i,
  input  wire logic [SIZE_PORT_W-1:0] size_units_i,
  input  wire logic                   starts_free_i,
  // fit strategy register write
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic                   fit_strategy_i,
  // result words
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [1:0]                  status_o,
  output logic [INDEX_PORT_W-1:0]     block_index_o,
  output logic [SIZE_PORT_W-1:0]      original_size_o,
  output logic [SIZE_PORT_W-1:0]      remainder_size_o,
  output logic [COUNT_PORT_W-1:0]     block_count_o
);

  fba_cmd_t  cmd;
  fba_stat_t stat;

  // Sequencer: decides which datapath step runs each cycle
  fba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Table RAM, scan compare, tail shift and result register
  fba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .kind_i           (kind_i),
    .size_units_i     (size_units_i),
    .starts_free_i    (starts_free_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .fit_strategy_i   (fit_strategy_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .block_index_o    (block_index_o),
    .original_size_o  (original_size_o),
    .remainder_size_o (remainder_size_o),
    .block_count_o    (block_count_o)
  );

endmodule

`default_nettype wire
